/* rtl/ppi_pkg.sv */
// ----------------------------------------------------------------------------
// Plane intersection package
// Shared constants, selection codes and pipeline record types.
// ----------------------------------------------------------------------------
package ppi_pkg;

   localparam int unsigned IN_BITS   = 160;
   localparam int unsigned OUT_BITS  = 200;
   localparam int unsigned THR_BITS  = 63;
   localparam int unsigned DIV_STEPS = 33;
   localparam logic [62:0] THR_RESET = 63'd720575940;

   // Which coordinate is pinned at zero.
   localparam logic [1:0] SEL_Z    = 2'd0;
   localparam logic [1:0] SEL_X    = 2'd1;
   localparam logic [1:0] SEL_Y    = 2'd2;
   localparam logic [1:0] SEL_NONE = 2'd3;

   typedef struct packed {
      logic               flag;
      logic [1:0]         sel;
      logic signed [32:0] dir_x;
      logic signed [32:0] dir_y;
      logic signed [32:0] dir_z;
      logic [62:0]        dvd0;
      logic [62:0]        dvd1;
      logic [31:0]        dvs;
      logic               neg0;
      logic               neg1;
   } front_type;

   typedef struct packed {
      logic               flag;
      logic [1:0]         sel;
      logic signed [32:0] dir_x;
      logic signed [32:0] dir_y;
      logic signed [32:0] dir_z;
      logic [31:0]        dvs;
      logic [65:0]        rq0;
      logic [65:0]        rq1;
      logic               sat0;
      logic               sat1;
      logic               neg0;
      logic               neg1;
   } stage_type;

endpackage

/* rtl/ppi_front.sv */
// ----------------------------------------------------------------------------
// Plane intersection front end
// Seven stages: cross product, numerators, squared length, parallel test.
// ----------------------------------------------------------------------------
module ppi_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [159:0]        in_data,
   input  logic [62:0]         thr,
   output logic                out_valid,
   output ppi_pkg::front_type  out_front
);

   logic [6:0] vld_ff;

   // Stage 1: captured inputs.
   logic signed [15:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic signed [31:0] ad_ff, bd_ff;
   // Stage 2: products.
   logic signed [31:0] pxa_ff, pxb_ff, pya_ff, pyb_ff, pza_ff, pzb_ff;
   logic signed [47:0] aybd_ff, byad_ff, bxad_ff, axbd_ff, azbd_ff, bzad_ff;
   // Stage 3: differences.
   logic signed [32:0] cx3_ff, cy3_ff, cz3_ff;
   logic signed [48:0] nz0_ff, n1_ff, nx0_ff, nx1_ff;
   // Stage 4: squares and selection.
   logic [63:0]        sqx_ff, sqy_ff, sqz_ff;
   logic signed [32:0] cx4_ff, cy4_ff, cz4_ff, det_ff;
   logic signed [48:0] n0s_ff, n1s_ff;
   logic [1:0]         sel4_ff;
   // Stage 5 to 7.
   logic [63:0]        sum5_ff, sqz5_ff, len6_ff;
   ppi_pkg::front_type f5_ff, f6_ff, f7_ff;

   logic signed [32:0] cx_in, cy_in, cz_in, det_in;
   logic signed [48:0] n0_in, n1_in;
   logic [1:0]         sel_in;
   logic [31:0]        mx_in, my_in, mz_in, mdet_in;
   logic [47:0]        mn0_in, mn1_in;
   ppi_pkg::front_type f7_in;

   always_comb begin
      cx_in = 33'(pxa_ff) - 33'(pxb_ff);
      cy_in = 33'(pya_ff) - 33'(pyb_ff);
      cz_in = 33'(pza_ff) - 33'(pzb_ff);
      // First nonzero determinant in the order z, x, y.
      if (cz3_ff != '0) begin
         sel_in = ppi_pkg::SEL_Z;
         det_in = cz3_ff;
         n0_in  = nz0_ff;
         n1_in  = n1_ff;
      end else if (cx3_ff != '0) begin
         sel_in = ppi_pkg::SEL_X;
         det_in = cx3_ff;
         n0_in  = nx0_ff;
         n1_in  = nx1_ff;
      end else if (cy3_ff != '0) begin
         sel_in = ppi_pkg::SEL_Y;
         det_in = -cy3_ff;
         n0_in  = nx0_ff;
         n1_in  = n1_ff;
      end else begin
         sel_in = ppi_pkg::SEL_NONE;
         det_in = '0;
         n0_in  = '0;
         n1_in  = '0;
      end
      mx_in   = cx3_ff[32] ? 32'(-cx3_ff) : 32'(cx3_ff);
      my_in   = cy3_ff[32] ? 32'(-cy3_ff) : 32'(cy3_ff);
      mz_in   = cz3_ff[32] ? 32'(-cz3_ff) : 32'(cz3_ff);
      mdet_in = det_ff[32] ? 32'(-det_ff) : 32'(det_ff);
      mn0_in  = n0s_ff[48] ? 48'(-n0s_ff) : 48'(n0s_ff);
      mn1_in  = n1s_ff[48] ? 48'(-n1s_ff) : 48'(n1s_ff);
      f7_in      = f6_ff;
      f7_in.flag = len6_ff < {1'b0, thr};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= in_data[15:0];
         ay_ff <= in_data[31:16];
         az_ff <= in_data[47:32];
         ad_ff <= in_data[79:48];
         bx_ff <= in_data[95:80];
         by_ff <= in_data[111:96];
         bz_ff <= in_data[127:112];
         bd_ff <= in_data[159:128];

         pxa_ff  <= 32'(ay_ff) * 32'(bz_ff);
         pxb_ff  <= 32'(az_ff) * 32'(by_ff);
         pya_ff  <= 32'(az_ff) * 32'(bx_ff);
         pyb_ff  <= 32'(ax_ff) * 32'(bz_ff);
         pza_ff  <= 32'(ax_ff) * 32'(by_ff);
         pzb_ff  <= 32'(ay_ff) * 32'(bx_ff);
         aybd_ff <= 48'(ay_ff) * 48'(bd_ff);
         byad_ff <= 48'(by_ff) * 48'(ad_ff);
         bxad_ff <= 48'(bx_ff) * 48'(ad_ff);
         axbd_ff <= 48'(ax_ff) * 48'(bd_ff);
         azbd_ff <= 48'(az_ff) * 48'(bd_ff);
         bzad_ff <= 48'(bz_ff) * 48'(ad_ff);

         cx3_ff <= cx_in;
         cy3_ff <= cy_in;
         cz3_ff <= cz_in;
         nz0_ff <= 49'(aybd_ff) - 49'(byad_ff);
         n1_ff  <= 49'(bxad_ff) - 49'(axbd_ff);
         nx0_ff <= 49'(azbd_ff) - 49'(bzad_ff);
         nx1_ff <= 49'(byad_ff) - 49'(aybd_ff);

         sqx_ff  <= 64'(mx_in) * 64'(mx_in);
         sqy_ff  <= 64'(my_in) * 64'(my_in);
         sqz_ff  <= 64'(mz_in) * 64'(mz_in);
         cx4_ff  <= cx3_ff;
         cy4_ff  <= cy3_ff;
         cz4_ff  <= cz3_ff;
         det_ff  <= det_in;
         n0s_ff  <= n0_in;
         n1s_ff  <= n1_in;
         sel4_ff <= sel_in;

         sum5_ff     <= sqx_ff + sqy_ff;
         sqz5_ff     <= sqz_ff;
         f5_ff.flag  <= 1'b0;
         f5_ff.sel   <= sel4_ff;
         f5_ff.dir_x <= cx4_ff;
         f5_ff.dir_y <= cy4_ff;
         f5_ff.dir_z <= cz4_ff;
         f5_ff.dvd0  <= 63'(mn0_in) << 14;
         f5_ff.dvd1  <= 63'(mn1_in) << 14;
         f5_ff.dvs   <= mdet_in;
         f5_ff.neg0  <= n0s_ff[48] ^ det_ff[32];
         f5_ff.neg1  <= n1s_ff[48] ^ det_ff[32];

         len6_ff <= sum5_ff + sqz5_ff;
         f6_ff   <= f5_ff;

         f7_ff <= f7_in;
      end
   end

   assign out_valid = vld_ff[6];
   assign out_front = f7_ff;

endmodule

/* rtl/ppi_solver.sv */
// ----------------------------------------------------------------------------
// Plane intersection solver
// Two-lane restoring divider, one quotient bit per stage, with overflow check.
// ----------------------------------------------------------------------------
module ppi_solver (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  ppi_pkg::front_type in_front,
   output logic               out_valid,
   output ppi_pkg::stage_type out_stage
);

   localparam int unsigned N = ppi_pkg::DIV_STEPS;

   logic [N:0]         vld_ff;
   ppi_pkg::stage_type st_ff [0:N];
   ppi_pkg::stage_type st_in;
   ppi_pkg::stage_type st_nx [1:N];

   // One restoring step: remainder in the upper half, dividend and quotient
   // share the lower half.
   function automatic logic [65:0] div_step(input logic [65:0] rq, input logic [31:0] v);
      logic [32:0] t;
      logic        b;
      t = {rq[64:33], rq[32]};
      b = t >= {1'b0, v};
      if (b) begin
         t = t - {1'b0, v};
      end
      return {t, rq[31:0], b};
   endfunction

   always_comb begin
      st_in.flag  = in_front.flag;
      st_in.sel   = in_front.sel;
      st_in.dir_x = in_front.dir_x;
      st_in.dir_y = in_front.dir_y;
      st_in.dir_z = in_front.dir_z;
      st_in.dvs   = in_front.dvs;
      st_in.rq0   = {3'b000, in_front.dvd0};
      st_in.rq1   = {3'b000, in_front.dvd1};
      // Quotient of 2^33 or more saturates whatever the low bits are.
      st_in.sat0  = 32'(in_front.dvd0[62:33]) >= in_front.dvs;
      st_in.sat1  = 32'(in_front.dvd1[62:33]) >= in_front.dvs;
      st_in.neg0  = in_front.neg0;
      st_in.neg1  = in_front.neg1;
   end

   always_comb begin
      for (int i = 1; i <= N; i++) begin
         st_nx[i]     = st_ff[i-1];
         st_nx[i].rq0 = div_step(st_ff[i-1].rq0, st_ff[i-1].dvs);
         st_nx[i].rq1 = div_step(st_ff[i-1].rq1, st_ff[i-1].dvs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= st_in;
         for (int i = 1; i <= N; i++) begin
            st_ff[i] <= st_nx[i];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_stage = st_ff[N];

endmodule

/* rtl/plane_plane_intersection_line.sv */
// ----------------------------------------------------------------------------
// Path: an accepted req beat passes the front stages, the divider stages and the output register to its rsp beat.
// Throughput: one beat per cycle while the output is not stalled, set by the fully pipelined 33-step divider.
// Reset: synchronous; clears valid bits and loads the default parallel threshold.
// ----------------------------------------------------------------------------
module plane_plane_intersection_line (
   input  logic         clock,
   input  logic         reset,
   // req_tdata, from the lowest bit: first_normal_x, first_normal_y,
   // first_normal_z, first_offset, second_normal_x, second_normal_y,
   // second_normal_z, second_offset.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,
   // rsp_tdata, from the lowest bit: point_x, point_y, point_z, dir_x, dir_y,
   // dir_z, then zero padding. rsp_tuser: parallel_flag.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [199:0] rsp_tdata,
   output logic         rsp_tuser,
   input  logic         csr_wen,
   input  logic [62:0]  csr_wdata
);

   // The whole pipeline advances as one whenever the output register is free
   // or being emptied this cycle; a stalled beat simply holds in place.
   logic               en;
   logic [62:0]        thr_ff;
   logic               fr_valid, sv_valid;
   ppi_pkg::front_type fr;
   ppi_pkg::stage_type sv;
   logic               rsp_valid_ff;
   logic [199:0]       rsp_data_ff;
   logic               rsp_user_ff;
   logic [31:0]        q0, q1, px_in, py_in, pz_in;
   logic [32:0]        dx_in, dy_in, dz_in;

   // Saturate the unsigned quotient magnitude and apply its sign.
   function automatic logic [31:0] sat_q(input logic [32:0] q, input logic sat,
                                         input logic neg);
      if (neg) begin
         return (sat || q > 33'h080000000) ? 32'h80000000 : 32'(-q);
      end
      return (sat || q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
   endfunction

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ppi_pkg::THR_RESET;
      end else if (csr_wen) begin
         thr_ff <= csr_wdata;
      end
   end

   ppi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .thr       (thr_ff),
      .out_valid (fr_valid),
      .out_front (fr)
   );

   ppi_solver u_solver (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_front  (fr),
      .out_valid (sv_valid),
      .out_stage (sv)
   );

   // Route the two quotients to the coordinates that were solved for; the
   // pinned coordinate stays zero. Parallel planes give all zeros.
   always_comb begin
      q0    = sat_q(sv.rq0[32:0], sv.sat0, sv.neg0);
      q1    = sat_q(sv.rq1[32:0], sv.sat1, sv.neg1);
      px_in = '0;
      py_in = '0;
      pz_in = '0;
      dx_in = sv.dir_x;
      dy_in = sv.dir_y;
      dz_in = sv.dir_z;
      if (sv.flag) begin
         dx_in = '0;
         dy_in = '0;
         dz_in = '0;
      end else begin
         case (sv.sel)
            ppi_pkg::SEL_Z: begin
               px_in = q0;
               py_in = q1;
            end
            ppi_pkg::SEL_X: begin
               py_in = q0;
               pz_in = q1;
            end
            ppi_pkg::SEL_Y: begin
               px_in = q0;
               pz_in = q1;
            end
            default: begin
               px_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {5'b00000, dz_in, dy_in, dx_in, pz_in, py_in, px_in};
         rsp_user_ff <= sv.flag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // Parallel planes carry no point and no direction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[194:0] == '0)
      else $error("parallel beat with nonzero payload");

   // A solved point always has one coordinate pinned at zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[31:0] == '0 || rsp_tdata[63:32] == '0 || rsp_tdata[95:64] == '0)
      else $error("no coordinate pinned at zero");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");
`endif

endmodule

/* dv/plane_plane_intersection_line_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Plane intersection line testbench
// Drives pairs of planes into the block, predicts the direction, the point and
// the parallel flag for each pair, and checks every result beat in order.
// The threshold is reprogrammed between phases, the extremes included.
// ----------------------------------------------------------------------------
module plane_plane_intersection_line_test;

   typedef struct packed {
      logic signed [31:0] bd;
      logic signed [15:0] bz;
      logic signed [15:0] by;
      logic signed [15:0] bx;
      logic signed [31:0] ad;
      logic signed [15:0] az;
      logic signed [15:0] ay;
      logic signed [15:0] ax;
   } plane_pair_type;

   typedef struct packed {
      logic               flag;
      logic [199:0]       data;
   } line_beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [199:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_wen = 1'b0;
   logic [62:0]  csr_wdata = '0;

   plane_pair_type pending_pairs[$];
   line_beat_type  expected_lines[$];
   logic [62:0]    threshold;
   int unsigned    send_idle_pct = 31;
   int unsigned    recv_idle_pct = 77;
   int             mismatches = 0;
   int             checked = 0;
   int             parallel_seen = 0;

   plane_plane_intersection_line dut (.*);

   // A 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Cramer's rule for one coordinate: widen the numerator by 2^14, divide
   // truncating toward zero, then clamp to the signed 32-bit range.
   function automatic logic [31:0] solve_coord(longint num, longint det);
      longint q;
      begin
         q = (num * 16384) / det;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         return q[31:0];
      end
   endfunction

   function automatic line_beat_type intersect_planes(plane_pair_type p, logic [62:0] thr);
      longint ax, ay, az, ad, bx, by, bz, bd, cx, cy, cz;
      logic [63:0] len2;
      logic [31:0] px, py, pz;
      line_beat_type r;
      begin
         ax = p.ax; ay = p.ay; az = p.az; ad = p.ad;
         bx = p.bx; by = p.by; bz = p.bz; bd = p.bd;
         cx = ay * bz - az * by;
         cy = az * bx - ax * bz;
         cz = ax * by - ay * bx;
         // Each component is below 2^31 in magnitude, so the sum fits 64 bits.
         len2 = cx * cx + cy * cy + cz * cz;
         px = '0; py = '0; pz = '0;
         r = '0;
         if (len2 < {1'b0, thr}) begin
            r.flag = 1'b1;
            return r;
         end
         if (cz != 0) begin
            px = solve_coord(ay * bd - by * ad, cz);
            py = solve_coord(bx * ad - ax * bd, cz);
         end else if (cx != 0) begin
            py = solve_coord(az * bd - bz * ad, cx);
            pz = solve_coord(by * ad - ay * bd, cx);
         end else if (cy != 0) begin
            px = solve_coord(az * bd - bz * ad, -cy);
            pz = solve_coord(bx * ad - ax * bd, -cy);
         end
         r.data = {5'b00000, cz[32:0], cy[32:0], cx[32:0], pz, py, px};
         return r;
      end
   endfunction

   // The driver keeps valid high while beats are pending and the sender is
   // not idling; the prediction is made as each beat is accepted.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_lines.push_back(intersect_planes(pending_pairs.pop_front(),
                                                      threshold));
         end
         if ((!req_tvalid || req_tready) ) begin
            if ((req_tvalid && req_tready ? pending_pairs.size() > 0
                                          : pending_pairs.size() > 0) &&
                $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_pairs[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // The monitor compares each result beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_lines.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result beat %h", rsp_tdata);
         end else begin
            line_beat_type e;
            e = expected_lines.pop_front();
            checked++;
            if (rsp_tuser) parallel_seen++;
            if (e.flag !== rsp_tuser || e.data !== rsp_tdata) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected flag %b data %h, got flag %b data %h",
                           e.flag, e.data, rsp_tuser, rsp_tdata);
            end
         end
      end
   end

   function automatic logic signed [15:0] rand_component(bit sparse);
      begin
         if (sparse && $urandom_range(3) == 0) return '0;
         case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(255) - 128);
            default: return 16'($urandom);
         endcase
      end
   endfunction

   function automatic plane_pair_type random_pair();
      plane_pair_type p;
      int shape;
      begin
         p.ax = rand_component(1); p.ay = rand_component(1); p.az = rand_component(1);
         p.bx = rand_component(1); p.by = rand_component(1); p.bz = rand_component(1);
         shape = $urandom_range(9);
         // Some pairs are exact copies or near copies so that the parallel
         // test and the fallback orders are exercised.
         if (shape == 0) begin
            p.bx = p.ax; p.by = p.ay; p.bz = p.az;
         end else if (shape == 1) begin
            p.bx = p.ax + 16'sd1; p.by = p.ay; p.bz = p.az;
         end
         p.ad = ($urandom_range(3) == 0) ? $urandom_range(1) ? 32'sh7FFFFFFF
                                                             : 32'sh80000000
                                         : $urandom;
         p.bd = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom;
         return p;
      end
   endfunction

   function automatic plane_pair_type make_pair(int ax, int ay, int az, int ad,
                                                int bx, int by, int bz, int bd);
      plane_pair_type p;
      begin
         p.ax = 16'(ax); p.ay = 16'(ay); p.az = 16'(az); p.ad = ad;
         p.bx = 16'(bx); p.by = 16'(by); p.bz = 16'(bz); p.bd = bd;
         return p;
      end
   endfunction

   // Waits for the queues to empty and the pipeline to drain before a write.
   task automatic drain_pipeline();
      begin
         while (pending_pairs.size() > 0 || req_tvalid || expected_lines.size() > 0)
            @(posedge clock);
         repeat (50) @(posedge clock);
      end
   endtask

   task automatic write_threshold(logic [62:0] value);
      begin
         @(posedge clock);
         csr_wen   <= 1'b1;
         csr_wdata <= value;
         threshold  = value;
         @(posedge clock);
         csr_wen   <= 1'b0;
      end
   endtask

   task automatic random_phase(int count, int unsigned s_idle, int unsigned r_idle);
      begin
         send_idle_pct = s_idle;
         recv_idle_pct = r_idle;
         repeat (count) pending_pairs.push_back(random_pair());
         drain_pipeline();
      end
   endtask

   initial begin
      threshold = ppi_pkg::THR_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed pairs at the reset threshold: axis planes for each pinned
      // coordinate, identical and opposite planes, and full-scale fields.
      pending_pairs.push_back(make_pair(16384, 0, 0, 65536, 0, 16384, 0, -65536));
      pending_pairs.push_back(make_pair(0, 16384, 0, 131072, 0, 0, 16384, 7));
      pending_pairs.push_back(make_pair(16384, 0, 0, -5, 0, 0, 16384, 9));
      pending_pairs.push_back(make_pair(16384, 0, 0, 3, 16384, 0, 0, 4));
      pending_pairs.push_back(make_pair(100, 200, 300, 1, -100, -200, -300, 2));
      pending_pairs.push_back(make_pair(32767, -32768, 32767, 32'h7FFFFFFF,
                                        -32768, 32767, -32768, 32'h80000000));
      pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32'h80000000,
                                        32767, -32768, 0, 32'h7FFFFFFF));
      pending_pairs.push_back(make_pair(1, 0, 0, 32'h7FFFFFFF, 0, 1, 0, 32'h80000000));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(2, 1, 0, 1000, 1, 1, 0, -1000));
      pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
      drain_pipeline();

      // Threshold zero: all-zero determinants without the parallel flag.
      write_threshold('0);
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(500, 0, 0, 9, 250, 0, 0, 3));
      pending_pairs.push_back(make_pair(1, 2, 3, 4, 5, 6, 7, 8));
      random_phase(250, 31, 77);

      // Largest threshold: nearly every pair counts as parallel.
      write_threshold({63{1'b1}});
      pending_pairs.push_back(make_pair(32767, 0, 0, 1, 0, 32767, 0, 1));
      random_phase(150, 77, 31);

      write_threshold(63'h0000_0001_0000_0000);
      random_phase(350, 0, 0);

      write_threshold(ppi_pkg::THR_RESET);
      random_phase(350, 0, 0);

      $display("Checked %0d result beats, %0d of them parallel, over five threshold settings.",
               checked, parallel_seen);
      if (mismatches == 0 && expected_lines.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end
endmodule
